// ----- sv/lrss_pkg.sv -----
// Shared types and codes for the LR shift-reduce parser step unit.
package lrss_pkg;

   localparam int SYM_W   = 6;
   localparam int STATE_W = 8;
   localparam int TYPE_W  = 2;
   localparam int RULE_W  = 8;
   localparam int LEN_W   = 4;
   localparam int DEPTH_W = 9;
   localparam int ACT_W   = TYPE_W + STATE_W;
   localparam int RULE_ENTRY_W = SYM_W + LEN_W;
   localparam int STK_W   = SYM_W + STATE_W;

   typedef enum logic [1:0] {
      KIND_PARSE   = 2'd0,
      KIND_ACTION  = 2'd1,
      KIND_RULE    = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef enum logic [TYPE_W-1:0] {
      ENT_ERROR  = 2'd0,
      ENT_SHIFT  = 2'd1,
      ENT_REDUCE = 2'd2,
      ENT_ACCEPT = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      OUT_SHIFTED  = 3'd0,
      OUT_REDUCED  = 3'd1,
      OUT_ACCEPTED = 3'd2,
      OUT_SYNTAX   = 3'd3,
      OUT_FAULT    = 3'd4,
      OUT_DONE     = 3'd5
   } outcome_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_ACT  = 5'b00010,
      PH_RULE = 5'b00100,
      PH_STK  = 5'b01000,
      PH_GOTO = 5'b10000
   } phase_type;

endpackage

// ----- sv/lrss_ram.sv -----
// Generic single-write, single-read RAM with registered, write-first read data.
module lrss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lr_shift_reduce_step_unit.sv -----
// Top level of the LR shift-reduce parser step unit.
// A result is registered. A reduce holds the unit through its dependent reads (action, rule,
// stack, goto), skipping the stack read when the rule is empty or uncovers the empty stack,
// and ending after the rule read on underflow. Throughput: one beat per cycle for shift,
// accept, error, load and restart beats while the receiver does not stall.
// Reset empties the stack (top state 0); the action, rule and stack memories are not cleared.
module lr_shift_reduce_step_unit import lrss_pkg::*; #(
   parameter int NUM_STATES  = 256,
   parameter int NUM_SYMBOLS = 64,
   parameter int NUM_RULES   = 256,
   parameter int STACK_DEPTH = 256,
   parameter int MAX_RHS     = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [SYM_W-1:0]   req_symbol_id,
   input  logic [STATE_W-1:0] req_state_index,
   input  logic [TYPE_W-1:0]  req_entry_type,
   input  logic [STATE_W-1:0] req_entry_value,
   input  logic [RULE_W-1:0]  req_rule_index,
   input  logic [SYM_W-1:0]   req_rule_lhs,
   input  logic [LEN_W-1:0]   req_rule_length,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_outcome,
   output logic [STATE_W-1:0] rsp_tos_state,
   output logic [DEPTH_W-1:0] rsp_stack_depth
);

   localparam int ACT_DEPTH = NUM_STATES * NUM_SYMBOLS;
   localparam int AAW = $clog2(ACT_DEPTH);
   localparam int RAW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   function automatic logic [AAW-1:0] act_addr(input logic [STATE_W-1:0] st,
                                                input logic [SYM_W-1:0] sym);
      act_addr = AAW'(AAW'(st) * AAW'(NUM_SYMBOLS) + AAW'(sym));
   endfunction

   function automatic logic in_table(input logic [STATE_W-1:0] st,
                                     input logic [SYM_W-1:0] sym);
      in_table = (32'(st) < NUM_STATES) && (32'(sym) < NUM_SYMBOLS);
   endfunction

   phase_type          phase_ff, phase_in;
   logic [SPW-1:0]     sp_ff, sp_in, sp_nx;
   logic [STATE_W-1:0] top_ff, top_in, top_nx;
   logic               abad_ff, abad_in;
   logic [SPW-1:0]     base_ff, base_in;
   logic [SYM_W-1:0]   lhs_ff, lhs_in;

   kind_type           kind_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic [STATE_W-1:0] srow_ff;
   logic [TYPE_W-1:0]  etype_ff;
   logic [STATE_W-1:0] evalue_ff;
   logic [RULE_W-1:0]  ridx_ff;
   logic [SYM_W-1:0]   rlhs_ff;
   logic [LEN_W-1:0]   rlen_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   outcome_type        rsp_outcome_ff;
   logic [STATE_W-1:0] rsp_tos_state_ff;
   logic [DEPTH_W-1:0] rsp_stack_depth_ff;

   logic               act_we, act_re;
   logic [AAW-1:0]     act_waddr, act_raddr;
   logic [ACT_W-1:0]   act_wdata, act_rdata;
   logic               rule_we, rule_re;
   logic [RAW-1:0]     rule_waddr, rule_raddr;
   logic [RULE_ENTRY_W-1:0] rule_wdata, rule_rdata;
   logic               stk_we, stk_re;
   logic [SAW-1:0]     stk_waddr, stk_raddr;
   logic [STK_W-1:0]   stk_wdata, stk_rdata;

   logic               fin, fire, out_free, take, accept;
   logic               act_want, rule_want, stk_want;
   logic               goto_re;
   logic [STATE_W-1:0] goto_state;
   logic [SYM_W-1:0]   goto_lhs;
   outcome_type        outcome;
   act_type            a_type;
   logic [STATE_W-1:0] a_val;
   logic [SYM_W-1:0]   r_lhs;
   logic [LEN_W-1:0]   r_len, rlen_sat;
   logic [SPW-1:0]     r_base;
   logic [SPW+DEPTH_W-1:0] depth_ext;

   assign a_type   = abad_ff ? ENT_ERROR : act_type'(act_rdata[ACT_W-1:STATE_W]);
   assign a_val    = act_rdata[STATE_W-1:0];
   assign r_lhs    = rule_rdata[RULE_ENTRY_W-1:LEN_W];
   assign r_len    = rule_rdata[LEN_W-1:0];
   assign r_base   = sp_ff - SPW'(r_len);
   assign rlen_sat = (32'(rlen_ff) > MAX_RHS) ? LEN_W'(MAX_RHS) : rlen_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      fin        = 1'b0;
      outcome    = OUT_DONE;
      act_want   = 1'b0;
      rule_want  = 1'b0;
      stk_want   = 1'b0;
      rule_re    = 1'b0;
      stk_re     = 1'b0;
      goto_re    = 1'b0;
      goto_state = top_ff;
      goto_lhs   = lhs_ff;
      sp_nx      = sp_ff;
      top_nx     = top_ff;
      base_in    = base_ff;
      lhs_in     = lhs_ff;
      phase_in   = phase_ff;
      stk_waddr  = SAW'(sp_ff);
      stk_wdata  = {sym_ff, a_val};
      stk_raddr  = SAW'(r_base - SPW'(1));
      case (phase_ff)
         PH_ACT: begin
            case (kind_ff)
               KIND_ACTION: begin
                  fin      = 1'b1;
                  act_want = in_table(srow_ff, sym_ff);
               end
               KIND_RULE: begin
                  fin       = 1'b1;
                  rule_want = 32'(ridx_ff) < NUM_RULES;
               end
               KIND_RESTART: begin
                  fin    = 1'b1;
                  sp_nx  = '0;
                  top_nx = '0;
               end
               KIND_PARSE: begin
                  case (a_type)
                     ENT_SHIFT: begin
                        fin = 1'b1;
                        if (32'(sp_ff) >= STACK_DEPTH) begin
                           outcome = OUT_FAULT;
                        end else begin
                           outcome  = OUT_SHIFTED;
                           stk_want = 1'b1;
                           sp_nx    = sp_ff + SPW'(1);
                           top_nx   = a_val;
                        end
                     end
                     ENT_REDUCE: begin
                        if (32'(a_val) >= NUM_RULES) begin
                           fin     = 1'b1;
                           outcome = OUT_SYNTAX;
                        end else begin
                           rule_re  = 1'b1;
                           phase_in = PH_RULE;
                        end
                     end
                     ENT_ACCEPT: begin
                        fin     = 1'b1;
                        outcome = OUT_ACCEPTED;
                     end
                     default: begin
                        fin     = 1'b1;
                        outcome = OUT_SYNTAX;
                     end
                  endcase
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         PH_RULE: begin
            if (SPW'(r_len) > sp_ff) begin
               fin     = 1'b1;
               outcome = OUT_FAULT;
            end else begin
               base_in  = r_base;
               lhs_in   = r_lhs;
               goto_lhs = r_lhs;
               if (r_len == '0) begin
                  goto_re    = 1'b1;
                  goto_state = top_ff;
                  phase_in   = PH_GOTO;
               end else if (r_base == '0) begin
                  goto_re    = 1'b1;
                  goto_state = '0;
                  phase_in   = PH_GOTO;
               end else begin
                  stk_re   = 1'b1;
                  phase_in = PH_STK;
               end
            end
         end
         PH_STK: begin
            goto_re    = 1'b1;
            goto_state = stk_rdata[STATE_W-1:0];
            phase_in   = PH_GOTO;
         end
         PH_GOTO: begin
            fin = 1'b1;
            if (a_type != ENT_SHIFT) begin
               outcome = OUT_SYNTAX;
            end else if (32'(base_ff) >= STACK_DEPTH) begin
               outcome = OUT_FAULT;
            end else begin
               outcome   = OUT_REDUCED;
               stk_want  = 1'b1;
               stk_waddr = SAW'(base_ff);
               stk_wdata = {lhs_ff, a_val};
               sp_nx     = base_ff + SPW'(1);
               top_nx    = a_val;
            end
         end
         default: begin
         end
      endcase

      fire    = fin && out_free;
      take    = (phase_ff == PH_IDLE) || fire;
      accept  = req_valid && take;
      act_we  = act_want && fire;
      rule_we = rule_want && fire;
      stk_we  = stk_want && fire;
      sp_in   = fire ? sp_nx : sp_ff;
      top_in  = fire ? top_nx : top_ff;

      if (fin || (phase_ff == PH_IDLE)) begin
         if (accept) begin
            phase_in = PH_ACT;
         end else if (fire) begin
            phase_in = PH_IDLE;
         end
      end

      act_re = accept || goto_re;
      if (goto_re) begin
         act_raddr = act_addr(goto_state, goto_lhs);
         abad_in   = !in_table(goto_state, goto_lhs);
      end else begin
         act_raddr = act_addr(top_in, req_symbol_id);
         abad_in   = accept ? !in_table(top_in, req_symbol_id) : abad_ff;
      end

      depth_ext = {{DEPTH_W{1'b0}}, sp_in};
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
   end

   assign act_waddr  = act_addr(srow_ff, sym_ff);
   assign act_wdata  = {etype_ff, evalue_ff};
   assign rule_waddr = RAW'(ridx_ff);
   assign rule_wdata = {rlhs_ff, rlen_sat};
   assign rule_raddr = RAW'(a_val);
   assign req_stall  = !take;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sp_ff        <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sp_ff        <= sp_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      abad_ff <= abad_in;
      base_ff <= base_in;
      lhs_ff  <= lhs_in;
      if (accept) begin
         kind_ff   <= kind_type'(req_kind);
         sym_ff    <= req_symbol_id;
         srow_ff   <= req_state_index;
         etype_ff  <= req_entry_type;
         evalue_ff <= req_entry_value;
         ridx_ff   <= req_rule_index;
         rlhs_ff   <= req_rule_lhs;
         rlen_ff   <= req_rule_length;
      end
      if (fire) begin
         rsp_outcome_ff     <= outcome;
         rsp_tos_state_ff   <= top_in;
         rsp_stack_depth_ff <= depth_ext[DEPTH_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_tos_state   = rsp_tos_state_ff;
   assign rsp_stack_depth = rsp_stack_depth_ff;

   lrss_ram #(.WIDTH(ACT_W), .DEPTH(ACT_DEPTH)) u_action_ram (
      .clock   (clock),
      .wr_en   (act_we),
      .wr_addr (act_waddr),
      .wr_data (act_wdata),
      .rd_en   (act_re),
      .rd_addr (act_raddr),
      .rd_data (act_rdata)
   );

   lrss_ram #(.WIDTH(RULE_ENTRY_W), .DEPTH(NUM_RULES)) u_rule_ram (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (rule_waddr),
      .wr_data (rule_wdata),
      .rd_en   (rule_re),
      .rd_addr (rule_raddr),
      .rd_data (rule_rdata)
   );

   lrss_ram #(.WIDTH(STK_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   a_accept_to_act: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (phase_ff == PH_ACT))
      else $error("accepted beat did not enter action phase");

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (32'(sp_ff) <= STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (sp_ff == '0) |-> (top_ff == '0))
      else $error("empty stack with nonzero top state");

   a_rule_read: assert property (@(posedge clock) disable iff (reset)
      rule_re |=> (phase_ff == PH_RULE))
      else $error("rule read without rule phase");

   a_fire_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> !($past(fire)) || $past(out_free))
      else $error("result overwrote a stalled beat");

endmodule

// ----- verif/lrss_step_checker.sv -----
// Checker for the LR parser step unit: watches both channels, predicts each result beat and compares.
`timescale 1ns / 1ps
module lrss_step_checker import lrss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [SYM_W-1:0]   req_symbol_id,
   input  logic [STATE_W-1:0] req_state_index,
   input  logic [TYPE_W-1:0]  req_entry_type,
   input  logic [STATE_W-1:0] req_entry_value,
   input  logic [RULE_W-1:0]  req_rule_index,
   input  logic [SYM_W-1:0]   req_rule_lhs,
   input  logic [LEN_W-1:0]   req_rule_length,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_outcome,
   input  logic [STATE_W-1:0] rsp_tos_state,
   input  logic [DEPTH_W-1:0] rsp_stack_depth,
   output int unsigned        fail_count,
   output int unsigned        pending_results,
   output int unsigned        checked_count,
   output int unsigned        reduce_count,
   output int unsigned        fault_count,
   output int unsigned        peak_depth
);

   localparam int STACK_LIMIT = 256;

   typedef struct packed {
      logic [2:0]         outcome;
      logic [STATE_W-1:0] tos_state;
      logic [DEPTH_W-1:0] stack_depth;
   } step_result_type;

   logic [ACT_W-1:0]        action_mem  [0:(1 << (STATE_W + SYM_W)) - 1];
   logic [RULE_ENTRY_W-1:0] rule_mem    [0:(1 << RULE_W) - 1];
   logic [STATE_W-1:0]      state_stack [0:STACK_LIMIT-1];
   int unsigned             depth;
   step_result_type         step_results_q [$];
   step_result_type         due_step;

   initial begin
      fail_count      = 0;
      pending_results = 0;
      checked_count   = 0;
      reduce_count    = 0;
      fault_count     = 0;
      peak_depth      = 0;
      depth           = 0;
   end

   function automatic logic [STATE_W-1:0] state_below(input int unsigned d);
      return (d == 0) ? '0 : state_stack[d-1];
   endfunction

   function automatic step_result_type advance_parser(
      input logic [1:0]         kind,
      input logic [SYM_W-1:0]   sym,
      input logic [STATE_W-1:0] row,
      input logic [TYPE_W-1:0]  etype,
      input logic [STATE_W-1:0] evalue,
      input logic [RULE_W-1:0]  ridx,
      input logic [SYM_W-1:0]   rlhs,
      input logic [LEN_W-1:0]   rlen
   );
      logic [ACT_W-1:0] act;
      logic [ACT_W-1:0] go;
      logic [SYM_W-1:0] lhs;
      logic [LEN_W-1:0] len;
      int unsigned      base;
      outcome_type      res;
      step_result_type  r;
      res = OUT_DONE;
      case (kind)
         KIND_ACTION: action_mem[{row, sym}] = {etype, evalue};
         KIND_RULE: rule_mem[ridx] = {rlhs, rlen};
         KIND_RESTART: depth = 0;
         default: begin
            act = action_mem[{state_below(depth), sym}];
            case (act[ACT_W-1 -: TYPE_W])
               ENT_SHIFT: begin
                  if (depth >= STACK_LIMIT) begin
                     res = OUT_FAULT;
                  end else begin
                     state_stack[depth] = act[STATE_W-1:0];
                     depth = depth + 1;
                     res = OUT_SHIFTED;
                  end
               end
               ENT_REDUCE: begin
                  {lhs, len} = rule_mem[act[STATE_W-1:0]];
                  if (len > depth) begin
                     res = OUT_FAULT;
                  end else begin
                     base = depth - len;
                     go = action_mem[{state_below(base), lhs}];
                     if (go[ACT_W-1 -: TYPE_W] != ENT_SHIFT) begin
                        res = OUT_SYNTAX;
                     end else if (base >= STACK_LIMIT) begin
                        res = OUT_FAULT;
                     end else begin
                        state_stack[base] = go[STATE_W-1:0];
                        depth = base + 1;
                        res = OUT_REDUCED;
                     end
                  end
               end
               ENT_ACCEPT: res = OUT_ACCEPTED;
               default: res = OUT_SYNTAX;
            endcase
         end
      endcase
      r.outcome     = res;
      r.tos_state   = state_below(depth);
      r.stack_depth = depth[DEPTH_W-1:0];
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [DEPTH_W-1:0] want,
                                       input logic [DEPTH_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         depth = 0;
         step_results_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (step_results_q.size() == 0) begin
               $error("result beat with no step outstanding: outcome %0d, tos_state %0d",
                      rsp_outcome, rsp_tos_state);
               fail_count++;
            end else begin
               due_step = step_results_q.pop_front();
               check_field("outcome", DEPTH_W'(due_step.outcome), DEPTH_W'(rsp_outcome));
               check_field("tos_state", DEPTH_W'(due_step.tos_state),
                           DEPTH_W'(rsp_tos_state));
               check_field("stack_depth", due_step.stack_depth, rsp_stack_depth);
               if (due_step.outcome == OUT_REDUCED) reduce_count++;
               if (due_step.outcome == OUT_FAULT) fault_count++;
               if (due_step.stack_depth > peak_depth) peak_depth = 32'(due_step.stack_depth);
            end
         end
         if (req_valid && !req_stall) begin
            step_results_q.push_back(advance_parser(req_kind, req_symbol_id, req_state_index,
               req_entry_type, req_entry_value, req_rule_index, req_rule_lhs, req_rule_length));
         end
      end
      pending_results = step_results_q.size();
   end

endmodule

// ----- verif/tb_lr_shift_reduce_step_unit.sv -----
// Testbench top for the LR parser step unit: stimulus, idling, pressure and the verdict.
`timescale 1ns / 1ps
module tb_lr_shift_reduce_step_unit import lrss_pkg::*; ();

   localparam int POOL_N      = 6;
   localparam int RULE_POOL_N = 8;
   localparam int MIX_BEATS   = 110;
   localparam int FILL_BEATS  = 258;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [1:0]         kind;
      logic [SYM_W-1:0]   symbol_id;
      logic [STATE_W-1:0] state_index;
      logic [TYPE_W-1:0]  entry_type;
      logic [STATE_W-1:0] entry_value;
      logic [RULE_W-1:0]  rule_index;
      logic [SYM_W-1:0]   rule_lhs;
      logic [LEN_W-1:0]   rule_length;
   } step_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = '0;
   logic [SYM_W-1:0]   req_symbol_id = '0;
   logic [STATE_W-1:0] req_state_index = '0;
   logic [TYPE_W-1:0]  req_entry_type = '0;
   logic [STATE_W-1:0] req_entry_value = '0;
   logic [RULE_W-1:0]  req_rule_index = '0;
   logic [SYM_W-1:0]   req_rule_lhs = '0;
   logic [LEN_W-1:0]   req_rule_length = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_outcome;
   logic [STATE_W-1:0] rsp_tos_state;
   logic [DEPTH_W-1:0] rsp_stack_depth;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned checked_count;
   int unsigned reduce_count;
   int unsigned fault_count;
   int unsigned peak_depth;

   int          idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_token = 1'b0;
   bit          hold_seen = 1'b0;
   int          hold_left = 0;
   int unsigned sent_count = 0;

   logic [STATE_W-1:0] state_pool [POOL_N];
   logic [SYM_W-1:0]   sym_pool [POOL_N];
   logic [RULE_W-1:0]  rule_pool [RULE_POOL_N];

   lr_shift_reduce_step_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_symbol_id   (req_symbol_id),
      .req_state_index (req_state_index),
      .req_entry_type  (req_entry_type),
      .req_entry_value (req_entry_value),
      .req_rule_index  (req_rule_index),
      .req_rule_lhs    (req_rule_lhs),
      .req_rule_length (req_rule_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_outcome     (rsp_outcome),
      .rsp_tos_state   (rsp_tos_state),
      .rsp_stack_depth (rsp_stack_depth)
   );

   lrss_step_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_symbol_id   (req_symbol_id),
      .req_state_index (req_state_index),
      .req_entry_type  (req_entry_type),
      .req_entry_value (req_entry_value),
      .req_rule_index  (req_rule_index),
      .req_rule_lhs    (req_rule_lhs),
      .req_rule_length (req_rule_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_outcome     (rsp_outcome),
      .rsp_tos_state   (rsp_tos_state),
      .rsp_stack_depth (rsp_stack_depth),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .checked_count   (checked_count),
      .reduce_count    (reduce_count),
      .fault_count     (fault_count),
      .peak_depth      (peak_depth)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hold off for a long stretch on each toggle of hold_token, otherwise stall at random
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic step_beat_type filler_beat();
      logic [63:0]   raw;
      step_beat_type b;
      raw = {$urandom, $urandom};
      b = raw[$bits(step_beat_type)-1:0];
      return b;
   endfunction

   function automatic step_beat_type parse_beat(input logic [SYM_W-1:0] sym);
      step_beat_type b;
      b = filler_beat();
      b.kind = KIND_PARSE;
      b.symbol_id = sym;
      return b;
   endfunction

   function automatic step_beat_type action_beat(input logic [STATE_W-1:0] row,
                                                 input logic [SYM_W-1:0] sym,
                                                 input logic [TYPE_W-1:0] etype,
                                                 input logic [STATE_W-1:0] evalue);
      step_beat_type b;
      b = filler_beat();
      b.kind = KIND_ACTION;
      b.state_index = row;
      b.symbol_id = sym;
      b.entry_type = etype;
      b.entry_value = evalue;
      return b;
   endfunction

   function automatic step_beat_type rule_beat(input logic [RULE_W-1:0] idx,
                                               input logic [SYM_W-1:0] lhs,
                                               input logic [LEN_W-1:0] len);
      step_beat_type b;
      b = filler_beat();
      b.kind = KIND_RULE;
      b.rule_index = idx;
      b.rule_lhs = lhs;
      b.rule_length = len;
      return b;
   endfunction

   function automatic step_beat_type restart_beat();
      step_beat_type b;
      b = filler_beat();
      b.kind = KIND_RESTART;
      return b;
   endfunction

   // shift and goto targets stay in the state pool, reduces name pooled rules only
   function automatic step_beat_type legal_action(input logic [STATE_W-1:0] row,
                                                  input logic [SYM_W-1:0] sym);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 45)
         return action_beat(row, sym, ENT_SHIFT, state_pool[$urandom_range(POOL_N-1)]);
      else if (pick < 75)
         return action_beat(row, sym, ENT_REDUCE, rule_pool[$urandom_range(RULE_POOL_N-1)]);
      else if (pick < 85)
         return action_beat(row, sym, ENT_ACCEPT, STATE_W'($urandom_range(255)));
      else
         return action_beat(row, sym, ENT_ERROR, STATE_W'($urandom_range(255)));
   endfunction

   function automatic step_beat_type legal_rule(input logic [RULE_W-1:0] idx);
      logic [LEN_W-1:0] len;
      len = LEN_W'(($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(15));
      return rule_beat(idx, sym_pool[$urandom_range(POOL_N-1)], len);
   endfunction

   function automatic step_beat_type mixed_step();
      int unsigned        pick;
      logic [STATE_W-1:0] row;
      logic [RULE_W-1:0]  idx;
      bit                 clash;
      step_beat_type      b;
      pick = $urandom_range(99);
      if (pick < 70) begin
         b = parse_beat(sym_pool[$urandom_range(POOL_N-1)]);
      end else if (pick < 80) begin
         b = legal_action(state_pool[$urandom_range(POOL_N-1)],
                          sym_pool[$urandom_range(POOL_N-1)]);
      end else if (pick < 85) begin
         b = legal_rule(rule_pool[$urandom_range(RULE_POOL_N-1)]);
      end else if (pick < 89) begin
         b = restart_beat();
      end else if (pick < 95) begin
         // scribble on a row that no parse can reach
         clash = 1'b1;
         while (clash) begin
            row = STATE_W'($urandom_range(255));
            clash = 1'b0;
            for (int i = 0; i < POOL_N; i++)
               if (state_pool[i] == row) clash = 1'b1;
         end
         b = action_beat(row, SYM_W'($urandom_range(63)), TYPE_W'($urandom_range(3)),
                         STATE_W'($urandom_range(255)));
      end else begin
         clash = 1'b1;
         while (clash) begin
            idx = RULE_W'($urandom_range(255));
            clash = 1'b0;
            for (int i = 0; i < RULE_POOL_N; i++)
               if (rule_pool[i] == idx) clash = 1'b1;
         end
         b = rule_beat(idx, SYM_W'($urandom_range(63)), LEN_W'($urandom_range(15)));
      end
      return b;
   endfunction

   // enter and leave at a falling edge; valid stays high for the caller to replace or drop
   task automatic offer_step(input step_beat_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= b.kind;
      req_symbol_id   <= b.symbol_id;
      req_state_index <= b.state_index;
      req_entry_type  <= b.entry_type;
      req_entry_value <= b.entry_value;
      req_rule_index  <= b.rule_index;
      req_rule_lhs    <= b.rule_lhs;
      req_rule_length <= b.rule_length;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
   endtask

   initial begin
      #5_000_000;
      $error("timeout with %0d results outstanding", pending_results);
      $display("lr_shift_reduce_step_unit: mismatch");
      $finish;
   end

   initial begin
      int unsigned waited;
      state_pool[0] = 8'd0;
      state_pool[1] = 8'd255;
      sym_pool[0]   = 6'd0;
      sym_pool[1]   = 6'd63;
      rule_pool[0]  = 8'd0;
      rule_pool[1]  = 8'd255;
      for (int i = 2; i < POOL_N; i++) begin
         state_pool[i] = STATE_W'($urandom_range(255));
         sym_pool[i]   = SYM_W'($urandom_range(63));
      end
      for (int i = 2; i < RULE_POOL_N; i++) rule_pool[i] = RULE_W'($urandom_range(255));

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_step(action_beat(8'd0, 6'd0, ENT_SHIFT, 8'd255));
      offer_step(action_beat(8'd255, 6'd63, ENT_SHIFT, 8'd0));
      offer_step(action_beat(8'd0, 6'd63, ENT_REDUCE, 8'd255));
      offer_step(rule_beat(8'd255, 6'd63, 4'd2));
      offer_step(action_beat(8'd255, 6'd0, ENT_REDUCE, 8'd0));
      offer_step(rule_beat(8'd0, 6'd0, 4'd15));
      offer_step(parse_beat(6'd63));    // reduce on empty stack: underflow
      offer_step(parse_beat(6'd0));
      offer_step(parse_beat(6'd63));
      offer_step(parse_beat(6'd63));    // goto entry is a reduce: syntax error
      offer_step(rule_beat(8'd255, 6'd0, 4'd2));
      offer_step(parse_beat(6'd63));    // pop two, goto back to state 255
      offer_step(parse_beat(6'd0));     // long rule on a shallow stack: underflow
      offer_step(action_beat(8'd255, 6'd0, ENT_ACCEPT, 8'd0));
      offer_step(parse_beat(6'd0));
      offer_step(action_beat(8'd255, 6'd63, ENT_ERROR, 8'd255));
      offer_step(parse_beat(6'd63));
      offer_step(restart_beat());
      offer_step(action_beat(8'd0, 6'd63, ENT_REDUCE, 8'd0));
      offer_step(rule_beat(8'd0, 6'd0, 4'd0));
      offer_step(parse_beat(6'd63));    // empty rule on the empty stack

      // fill every pooled state and symbol pair, then every pooled rule
      for (int i = 0; i < POOL_N; i++)
         for (int j = 0; j < POOL_N; j++)
            offer_step(legal_action(state_pool[i], sym_pool[j]));
      for (int k = 0; k < RULE_POOL_N; k++) offer_step(legal_rule(rule_pool[k]));
      drain_results();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 76; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 76; end
            default: begin idle_pct = 14; stall_pct <= 14; end
         endcase
         repeat (MIX_BEATS) offer_step(mixed_step());
         drain_results();
      end

      // fill the stack to the top while the receiver holds off
      idle_pct = 0;
      stall_pct <= 0;
      hold_token <= ~hold_token;
      offer_step(restart_beat());
      for (int i = 0; i < POOL_N; i++)
         for (int j = 0; j < POOL_N; j++)
            offer_step(action_beat(state_pool[i], sym_pool[j], ENT_SHIFT, 8'd0));
      repeat (FILL_BEATS) offer_step(parse_beat(sym_pool[$urandom_range(POOL_N-1)]));
      offer_step(action_beat(8'd0, 6'd0, ENT_REDUCE, 8'd0));
      offer_step(rule_beat(8'd0, 6'd63, 4'd0));
      offer_step(parse_beat(6'd0));     // empty rule on a full stack: overflow
      offer_step(rule_beat(8'd0, 6'd63, 4'd1));
      offer_step(parse_beat(6'd0));
      offer_step(rule_beat(8'd0, 6'd63, 4'd15));
      offer_step(parse_beat(6'd0));

      req_valid <= 1'b0;
      waited = 0;
      while (pending_results != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (pending_results != 0) $error("%0d results never arrived", pending_results);
      $display("Sent %0d step beats under four idle/stall mixes plus a full-stack pass.",
               sent_count);
      $display("Checked %0d results: %0d reduces, %0d stack faults, deepest stack %0d.",
               checked_count, reduce_count, fault_count, peak_depth);
      if (fail_count == 0 && pending_results == 0)
         $display("lr_shift_reduce_step_unit: match");
      else
         $display("lr_shift_reduce_step_unit: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/lrss_pkg.sv
sv/lrss_ram.sv
sv/lr_shift_reduce_step_unit.sv
verif/lrss_step_checker.sv
verif/tb_lr_shift_reduce_step_unit.sv
